// ===== rtl/core/token_lexer_assert.svh =====
// assertion macros for the token lexer
`ifndef TOKEN_LEXER_ASSERT_SVH
`define TOKEN_LEXER_ASSERT_SVH
`ifndef SYNTHESIS
`define TL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define TL_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define TL_ASSERT(label, clk, rst_n, prop)
`define TL_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/tlex_pkg.sv =====
package tlex_pkg;

  localparam int unsigned MaxTextBytes = 65536;
  localparam logic [15:0] Sat16 = 16'hFFFF;

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeComment = 3'd1,
    ModeString  = 3'd2,
    ModeInt     = 3'd3,
    ModeFrac    = 3'd4,
    ModeIdent   = 3'd5,
    ModeOp      = 3'd6
  } lex_mode_e;

  typedef enum logic [2:0] {
    KindInvalid   = 3'd0,
    KindNumber    = 3'd1,
    KindString    = 3'd2,
    KindIdent     = 3'd3,
    KindKeyword   = 3'd4,
    KindOperator  = 3'd5,
    KindSeparator = 3'd6
  } token_kind_e;

  localparam logic [3:0] KwVar = 4'd0;
  localparam logic [3:0] KwTrue = 4'd1;
  localparam logic [3:0] KwFalse = 4'd2;
  localparam logic [3:0] OpEqEq = 4'd0;
  localparam logic [3:0] OpPlusPlus = 4'd1;
  localparam logic [3:0] OpMinusMinus = 4'd2;
  localparam logic [3:0] OpEq = 4'd3;
  localparam logic [3:0] OpPlus = 4'd4;
  localparam logic [3:0] OpMinus = 4'd5;
  localparam logic [3:0] OpStar = 4'd6;
  localparam logic [3:0] OpSlash = 4'd7;
  localparam logic [3:0] OpDot = 4'd8;
  localparam logic [3:0] OpAnd = 4'd9;
  localparam logic [3:0] OpOr = 4'd10;
  localparam logic [3:0] SepLParen = 4'd0;
  localparam logic [3:0] SepRParen = 4'd1;
  localparam logic [3:0] SepLBracket = 4'd2;
  localparam logic [3:0] SepRBracket = 4'd3;
  localparam logic [3:0] SepLBrace = 4'd4;
  localparam logic [3:0] SepRBrace = 4'd5;
  localparam logic [3:0] SepComma = 4'd6;

  // token before classification of identifiers
  typedef struct packed {
    logic        is_word;
    token_kind_e kind;
    logic [3:0]  code;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic [39:0] prefix;
    logic        err;
    logic        last;
  } tok_t;

  function automatic logic [15:0] sat_inc(logic [15:0] v, logic [15:0] cap);
    return (v < cap) ? v + 16'd1 : cap;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

// ===== rtl/core/token_lexer.sv =====
// channel  | handshake        | fields
// input    | push / full      | char_byte_i, end_of_input_i
// result   | empty / pop      | token_kind_o .. last_of_run_o
// one byte per cycle; the scanner emits up to two tokens into a four-word queue.
// full rises while fewer than two queue slots are free, so the input stalls only
// when results are not popped. reset is asynchronous and empties the queue.
// result words are held in the queue from the cycle after the byte that causes them, behind any older words.
`include "token_lexer_assert.svh"
module token_lexer import tlex_pkg::*; #(
  parameter int unsigned MAX_TEXT_BYTES = MaxTextBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_input_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  token_kind_o,
  output logic [3:0]  symbol_code_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] text_length_o,
  output logic [15:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic        error_seen_o,
  output logic        last_of_run_o
);

  logic accept, v0, v1, room;
  tok_t t0, t1, head;

  assign full = !room;
  assign accept = push && room;

  tlex_front #(.MAX_TEXT_BYTES(MAX_TEXT_BYTES)) u_front (
    .clk_i, .rst_ni, .valid_i(accept), .char_byte_i, .end_of_input_i,
    .tok0_valid_o(v0), .tok1_valid_o(v1), .tok0_o(t0), .tok1_o(t1)
  );

  tlex_queue u_queue (
    .clk_i, .rst_ni, .wr0_i(accept && v0), .wr1_i(accept && v1),
    .wdata0_i(t0), .wdata1_i(t1), .room_o(room), .empty_o(empty),
    .rd_i(pop && !empty), .rdata_o(head)
  );

  tlex_back u_back (
    .tok_i(head), .token_kind_o, .symbol_code_o, .start_offset_o, .text_length_o,
    .line_number_o, .column_number_o, .error_seen_o, .last_of_run_o
  );

  `TL_ASSERT(a_two_marks_last, clk_i, rst_ni, (accept && v1) |-> (t1.last && !t0.last))
  `TL_ASSERT(a_push_fills, clk_i, rst_ni, (accept && v0) |=> !empty)
  `TL_ASSERT_NEVER(a_full_no_accept, clk_i, rst_ni, (full && accept))

endmodule

// ===== rtl/core/tlex_front.sv =====
// scans bytes, keeps the pending token, produces up to two raw tokens per byte
module tlex_front import tlex_pkg::*; #(
  parameter int unsigned MAX_TEXT_BYTES = MaxTextBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_input_i,
  output logic       tok0_valid_o,
  output logic       tok1_valid_o,
  output tok_t       tok0_o,
  output tok_t       tok1_o
);

  localparam logic [15:0] PosCap =
      (MAX_TEXT_BYTES - 1 > 65535) ? 16'hFFFF : 16'(MAX_TEXT_BYTES - 1);

  lex_mode_e   mode_q, mode_d;
  logic [15:0] pstart_q, pstart_d, plen_q, plen_d, pline_q, pline_d, pcol_q, pcol_d;
  logic [39:0] prefix_q, prefix_d;
  logic [7:0]  opch_q, opch_d;
  logic [15:0] pos_q, pos_d, line_q, line_d, col_q, col_d;
  logic        err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      pstart_q <= '0;
      plen_q   <= '0;
      pline_q  <= 16'd1;
      pcol_q   <= 16'd1;
      prefix_q <= '0;
      opch_q   <= '0;
      pos_q    <= '0;
      line_q   <= 16'd1;
      col_q    <= 16'd1;
      err_q    <= 1'b0;
    end else if (valid_i) begin
      mode_q   <= mode_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      pline_q  <= pline_d;
      pcol_q   <= pcol_d;
      prefix_q <= prefix_d;
      opch_q   <= opch_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      col_q    <= col_d;
      err_q    <= err_d;
    end
  end

  always_comb begin
    logic [7:0] c;
    logic       fresh;
    logic [1:0] n;
    tok_t       t;
    tok_t       toks [2];
    c = char_byte_i;
    fresh = 1'b0;
    n = '0;
    toks[0] = '0;
    toks[1] = '0;
    mode_d = mode_q;
    pstart_d = pstart_q;
    plen_d = plen_q;
    pline_d = pline_q;
    pcol_d = pcol_q;
    prefix_d = prefix_q;
    opch_d = opch_q;
    err_d = err_q;
    // pending token template
    t = '0;
    t.start = pstart_q;
    t.line = pline_q;
    t.col = pcol_q;
    t.len = plen_q;
    t.prefix = prefix_q;

    case (mode_q)
      ModeComment: if (c == 8'h0A) mode_d = ModeIdle;
      ModeString: begin
        if (c == "\"") begin
          t.kind = KindString;
          toks[n[0]] = t;
          n = n + 2'd1;
          mode_d = ModeIdle;
        end else begin
          plen_d = sat_inc(plen_q, Sat16);
        end
      end
      ModeInt, ModeFrac: begin
        if (is_digit(c)) begin
          plen_d = sat_inc(plen_q, Sat16);
        end else if (c == "." && mode_q == ModeInt) begin
          plen_d = sat_inc(plen_q, Sat16);
          mode_d = ModeFrac;
        end else begin
          t.kind = KindNumber;
          toks[n[0]] = t;
          n = n + 2'd1;
          fresh = 1'b1;
        end
      end
      ModeIdent: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          if (plen_q < 16'd5) prefix_d = {prefix_q[31:0], c};
          plen_d = sat_inc(plen_q, Sat16);
        end else begin
          t.is_word = 1'b1;
          t.kind = KindIdent;
          toks[n[0]] = t;
          n = n + 2'd1;
          fresh = 1'b1;
        end
      end
      ModeOp: begin
        t.kind = KindOperator;
        if (c == opch_q) begin
          t.len = 16'd2;
          t.code = (c == "=") ? OpEqEq : (c == "+") ? OpPlusPlus : OpMinusMinus;
          toks[n[0]] = t;
          n = n + 2'd1;
          mode_d = ModeIdle;
        end else begin
          t.code = (opch_q == "=") ? OpEq : (opch_q == "+") ? OpPlus : OpMinus;
          toks[n[0]] = t;
          n = n + 2'd1;
          fresh = 1'b1;
        end
      end
      default: fresh = 1'b1;
    endcase

    if (fresh) begin
      t = '0;
      t.start = pos_q;
      t.len = 16'd1;
      t.line = line_q;
      t.col = col_q;
      mode_d = ModeIdle;
      if (is_space(c)) begin
      end else if (c == "#") begin
        mode_d = ModeComment;
      end else if (c == "\"") begin
        mode_d = ModeString;
        pstart_d = sat_inc(pos_q, PosCap);
        plen_d = '0;
        pline_d = line_q;
        pcol_d = sat_inc(col_q, Sat16);
      end else if (is_digit(c) || is_alpha(c) || c == "_" ||
                   c == "=" || c == "+" || c == "-") begin
        mode_d = is_digit(c) ? ModeInt : (c == "=" || c == "+" || c == "-") ? ModeOp
                                                                          : ModeIdent;
        pstart_d = pos_q;
        plen_d = 16'd1;
        pline_d = line_q;
        pcol_d = col_q;
        if (mode_d == ModeIdent) prefix_d = {32'd0, c};
        if (mode_d == ModeOp) opch_d = c;
      end else begin
        case (c)
          "*": begin t.kind = KindOperator; t.code = OpStar; end
          "/": begin t.kind = KindOperator; t.code = OpSlash; end
          ".": begin t.kind = KindOperator; t.code = OpDot; end
          "(": begin t.kind = KindSeparator; t.code = SepLParen; end
          ")": begin t.kind = KindSeparator; t.code = SepRParen; end
          "[": begin t.kind = KindSeparator; t.code = SepLBracket; end
          "]": begin t.kind = KindSeparator; t.code = SepRBracket; end
          "{": begin t.kind = KindSeparator; t.code = SepLBrace; end
          "}": begin t.kind = KindSeparator; t.code = SepRBrace; end
          ",": begin t.kind = KindSeparator; t.code = SepComma; end
          default: t.kind = KindInvalid;
        endcase
        toks[n[0]] = t;
        n = n + 2'd1;
      end
    end

    // flush at end of text
    if (end_of_input_i) begin
      t = '0;
      t.start = pstart_d;
      t.len = plen_d;
      t.line = pline_d;
      t.col = pcol_d;
      t.prefix = prefix_d;
      case (mode_d)
        ModeString: begin t.kind = KindString; toks[n[0]] = t; n = n + 2'd1; end
        ModeInt, ModeFrac: begin t.kind = KindNumber; toks[n[0]] = t; n = n + 2'd1; end
        ModeIdent: begin
          t.kind = KindIdent;
          t.is_word = 1'b1;
          toks[n[0]] = t;
          n = n + 2'd1;
        end
        ModeOp: begin
          t.kind = KindOperator;
          t.code = (opch_d == "=") ? OpEq : (opch_d == "+") ? OpPlus : OpMinus;
          toks[n[0]] = t;
          n = n + 2'd1;
        end
        default: ;
      endcase
    end

    // sticky error, in token order
    for (int i = 0; i < 2; i++) begin
      if (n > 2'(i) && toks[i].kind == KindInvalid && !toks[i].is_word) err_d = 1'b1;
      toks[i].err = err_d;
    end
    if (n == 2'd2) toks[1].last = 1'b1;
    else toks[0].last = 1'b1;

    tok0_valid_o = n != 2'd0;
    tok1_valid_o = n == 2'd2;
    tok0_o = toks[0];
    tok1_o = toks[1];

    if (end_of_input_i) begin
      mode_d = ModeIdle;
      pstart_d = '0;
      plen_d = '0;
      pline_d = 16'd1;
      pcol_d = 16'd1;
      prefix_d = '0;
      opch_d = '0;
      pos_d = '0;
      line_d = 16'd1;
      col_d = 16'd1;
      err_d = 1'b0;
    end else begin
      pos_d = sat_inc(pos_q, PosCap);
      line_d = (c == 8'h0A) ? sat_inc(line_q, Sat16) : line_q;
      col_d = (c == 8'h0A) ? 16'd1 : sat_inc(col_q, Sat16);
    end
  end

endmodule

// ===== rtl/core/tlex_queue.sv =====
// token queue between the scanner and the result side, up to two writes per cycle
`include "token_lexer_assert.svh"
module tlex_queue import tlex_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr0_i,
  input  logic wr1_i,
  input  tok_t wdata0_i,
  input  tok_t wdata1_i,
  output logic room_o,
  output logic empty_o,
  input  logic rd_i,
  output tok_t rdata_o
);

  localparam int unsigned Depth = 4;

  tok_t        mem_q [Depth];
  logic [1:0]  wptr_q, rptr_q;
  logic [2:0]  cnt_q;
  logic [1:0]  nwr;

  assign nwr = {1'b0, wr0_i} + {1'b0, wr1_i};
  // room for two so a byte is never refused mid-way
  assign room_o = cnt_q <= 3'(Depth - 2);
  assign empty_o = cnt_q == 3'd0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr0_i) mem_q[wptr_q] <= wdata0_i;
    if (wr1_i) mem_q[wptr_q + 2'd1] <= wdata1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + nwr;
      rptr_q <= rptr_q + 2'(rd_i);
      cnt_q  <= cnt_q + 3'(nwr) - 3'(rd_i);
    end
  end

  `TL_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, (cnt_q + 3'(nwr) > 3'(Depth)))
  `TL_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, (rd_i && cnt_q == 3'd0))
  `TL_ASSERT_NEVER(a_second_alone, clk_i, rst_ni, (wr1_i && !wr0_i))

endmodule

// ===== rtl/core/tlex_back.sv =====
// classifies identifiers against the keyword and word-operator table and drives the result word
module tlex_back import tlex_pkg::*; (
  input  tok_t        tok_i,
  output logic [2:0]  token_kind_o,
  output logic [3:0]  symbol_code_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] text_length_o,
  output logic [15:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic        error_seen_o,
  output logic        last_of_run_o
);

  always_comb begin
    token_kind_o = tok_i.kind;
    symbol_code_o = tok_i.code;
    if (tok_i.is_word) begin
      if (tok_i.len == 16'd3 && tok_i.prefix == 40'h766172) begin
        token_kind_o = KindKeyword; symbol_code_o = KwVar;
      end else if (tok_i.len == 16'd4 && tok_i.prefix == 40'h74727565) begin
        token_kind_o = KindKeyword; symbol_code_o = KwTrue;
      end else if (tok_i.len == 16'd5 && tok_i.prefix == 40'h66616C7365) begin
        token_kind_o = KindKeyword; symbol_code_o = KwFalse;
      end else if (tok_i.len == 16'd3 && tok_i.prefix == 40'h616E64) begin
        token_kind_o = KindOperator; symbol_code_o = OpAnd;
      end else if (tok_i.len == 16'd2 && tok_i.prefix == 40'h6F72) begin
        token_kind_o = KindOperator; symbol_code_o = OpOr;
      end
    end
    start_offset_o = tok_i.start;
    text_length_o = tok_i.len;
    line_number_o = tok_i.line;
    column_number_o = tok_i.col;
    error_seen_o = tok_i.err;
    last_of_run_o = tok_i.last;
  end

endmodule

// ===== sim/token_lexer_checker.sv =====
module token_lexer_checker import tlex_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_input_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  token_kind_o,
  input  logic [3:0]  symbol_code_o,
  input  logic [15:0] start_offset_o,
  input  logic [15:0] text_length_o,
  input  logic [15:0] line_number_o,
  input  logic [15:0] column_number_o,
  input  logic        error_seen_o,
  input  logic        last_of_run_o,
  output int          fail_count,
  output int          tokens_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    token_kind_e kind;
    logic [3:0]  code;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        err;
    logic        last;
  } token_t;

  localparam logic [15:0] PosCap = (MaxTextBytes - 1 > 65535) ? 16'hFFFF : 16'(MaxTextBytes - 1);

  token_t token_queue[$];

  lex_mode_e   mode;
  logic [15:0] tok_start, tok_len, tok_line, tok_col, pos, cur_line, cur_col;
  logic [39:0] prefix;
  logic [7:0]  op_char;
  logic        err_flag;

  function automatic logic [15:0] bump(logic [15:0] v, logic [15:0] cap);
    return (v < cap) ? v + 16'd1 : cap;
  endfunction

  function automatic logic digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  task automatic clear_lexer();
    mode = ModeIdle; tok_start = '0; tok_len = '0; tok_line = 16'd1; tok_col = 16'd1;
    prefix = '0; op_char = '0; pos = '0; cur_line = 16'd1; cur_col = 16'd1;
    err_flag = 1'b0;
  endtask

  task automatic add_token(token_kind_e k, logic [3:0] code, logic [15:0] s, logic [15:0] l,
                           logic [15:0] ln, logic [15:0] cl);
    token_t t;
    if (k == KindInvalid) err_flag = 1'b1;
    t.kind = k; t.code = code; t.start = s; t.len = l; t.line = ln; t.col = cl;
    t.err = err_flag; t.last = 1'b0;
    token_queue.insert(token_queue.size(), t);
  endtask

  task automatic add_pending(token_kind_e k, logic [3:0] code);
    add_token(k, code, tok_start, tok_len, tok_line, tok_col);
  endtask

  task automatic add_word();
    token_kind_e k;
    logic [3:0]  code;
    k = KindIdent; code = 4'd0;
    if (tok_len == 16'd3 && prefix == 40'h766172) begin k = KindKeyword; code = KwVar; end
    else if (tok_len == 16'd4 && prefix == 40'h74727565) begin
      k = KindKeyword; code = KwTrue;
    end
    else if (tok_len == 16'd5 && prefix == 40'h66616C7365) begin
      k = KindKeyword; code = KwFalse;
    end
    else if (tok_len == 16'd3 && prefix == 40'h616E64) begin
      k = KindOperator; code = OpAnd;
    end
    else if (tok_len == 16'd2 && prefix == 40'h6F72) begin k = KindOperator; code = OpOr; end
    add_pending(k, code);
  endtask

  function automatic logic [3:0] single_op(logic [7:0] c);
    return (c == "=") ? OpEq : (c == "+") ? OpPlus : OpMinus;
  endfunction

  task automatic start_pending(lex_mode_e m, logic [15:0] s, logic [15:0] l, logic [15:0] ln,
                               logic [15:0] cl);
    mode = m; tok_start = s; tok_len = l; tok_line = ln; tok_col = cl;
  endtask

  task automatic scan_fresh(logic [7:0] c);
    mode = ModeIdle;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    if (c == "#") mode = ModeComment;
    else if (c == "\"") start_pending(ModeString, bump(pos, PosCap), 16'd0, cur_line,
                                      bump(cur_col, 16'hFFFF));
    else if (digit(c)) start_pending(ModeInt, pos, 16'd1, cur_line, cur_col);
    else if (letter(c) || c == "_") begin
      start_pending(ModeIdent, pos, 16'd1, cur_line, cur_col);
      prefix = {32'd0, c};
    end else if (c == "=" || c == "+" || c == "-") begin
      start_pending(ModeOp, pos, 16'd1, cur_line, cur_col);
      op_char = c;
    end else begin
      case (c)
        "*": add_token(KindOperator, OpStar, pos, 16'd1, cur_line, cur_col);
        "/": add_token(KindOperator, OpSlash, pos, 16'd1, cur_line, cur_col);
        ".": add_token(KindOperator, OpDot, pos, 16'd1, cur_line, cur_col);
        "(": add_token(KindSeparator, SepLParen, pos, 16'd1, cur_line, cur_col);
        ")": add_token(KindSeparator, SepRParen, pos, 16'd1, cur_line, cur_col);
        "[": add_token(KindSeparator, SepLBracket, pos, 16'd1, cur_line, cur_col);
        "]": add_token(KindSeparator, SepRBracket, pos, 16'd1, cur_line, cur_col);
        "{": add_token(KindSeparator, SepLBrace, pos, 16'd1, cur_line, cur_col);
        "}": add_token(KindSeparator, SepRBrace, pos, 16'd1, cur_line, cur_col);
        ",": add_token(KindSeparator, SepComma, pos, 16'd1, cur_line, cur_col);
        default: add_token(KindInvalid, 4'd0, pos, 16'd1, cur_line, cur_col);
      endcase
    end
  endtask

  task automatic lex_byte(logic [7:0] c, logic eoi);
    int   prior_size;
    logic fresh;
    prior_size = token_queue.size();
    fresh = 1'b0;
    case (mode)
      ModeComment: if (c == "\n") mode = ModeIdle;
      ModeString: begin
        if (c == "\"") begin
          add_pending(KindString, 4'd0); mode = ModeIdle;
        end else tok_len = bump(tok_len, 16'hFFFF);
      end
      ModeInt, ModeFrac: begin
        if (digit(c)) tok_len = bump(tok_len, 16'hFFFF);
        else if (c == "." && mode == ModeInt) begin
          tok_len = bump(tok_len, 16'hFFFF); mode = ModeFrac;
        end else begin
          add_pending(KindNumber, 4'd0); fresh = 1'b1;
        end
      end
      ModeIdent: begin
        if (letter(c) || digit(c) || c == "_") begin
          if (tok_len < 16'd5) prefix = {prefix[31:0], c};
          tok_len = bump(tok_len, 16'hFFFF);
        end else begin
          add_word(); fresh = 1'b1;
        end
      end
      ModeOp: begin
        if (c == op_char) begin
          tok_len = 16'd2;
          add_pending(KindOperator, (c == "=") ? OpEqEq : (c == "+") ? OpPlusPlus : OpMinusMinus);
          mode = ModeIdle;
        end else begin
          add_pending(KindOperator, single_op(op_char)); fresh = 1'b1;
        end
      end
      default: fresh = 1'b1;
    endcase
    if (fresh) scan_fresh(c);
    if (eoi) begin
      case (mode)
        ModeString: add_pending(KindString, 4'd0);
        ModeInt, ModeFrac: add_pending(KindNumber, 4'd0);
        ModeIdent: add_word();
        ModeOp: add_pending(KindOperator, single_op(op_char));
        default: ;
      endcase
      clear_lexer();
    end else begin
      pos = bump(pos, PosCap);
      if (c == "\n") begin
        cur_line = bump(cur_line, 16'hFFFF); cur_col = 16'd1;
      end else cur_col = bump(cur_col, 16'hFFFF);
    end
    if (token_queue.size() > prior_size) token_queue[token_queue.size() - 1].last = 1'b1;
  endtask

  initial begin
    fail_count = 0;
    clear_lexer();
  end

  assign tokens_waiting = token_queue.size();

  always @(posedge clk_i) begin
    token_t got, want;
    if (rst_ni) begin
      // result side first: a word popped now was caused by an earlier byte
      if (pop && !empty) begin
        got = {token_kind_e'(token_kind_o), symbol_code_o, start_offset_o, text_length_o,
               line_number_o, column_number_o, error_seen_o, last_of_run_o};
        if (token_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected word: %p", got);
        end else begin
          want = token_queue.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("word mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (push && !full) lex_byte(char_byte_i, end_of_input_i);
    end
  end
endmodule

// ===== sim/token_lexer_test.sv =====
module token_lexer_test import tlex_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 0, rst_ni = 0, push = 0, pop = 0, end_of_input_i = 0;
  logic [7:0]  char_byte_i = 0;
  logic        full, empty, error_seen_o, last_of_run_o;
  logic [2:0]  token_kind_o;
  logic [3:0]  symbol_code_o;
  logic [15:0] start_offset_o, text_length_o, line_number_o, column_number_o;
  int          fail_count, tokens_waiting;
  bit          calm = 0, hold_off = 0;

  token_lexer uut (.*);
  token_lexer_checker checker_i (.*);

  initial forever #5 clk_i = ~clk_i;

  // bytes worth picking often: every class plus keyword letters
  byte unsigned alphabet[] = '{" ", "\n", "\t", "#", "\"", "0", "7", "9", ".", "a", "n", "d",
    "o", "r", "v", "t", "u", "e", "f", "l", "s", "_", "Z", "=", "+", "-", "*", "/", "(",
    ")", "[", "]", "{", "}", ",", "@", 8'h7F, 8'hFF, 8'h80, 8'h00};

  // called at a falling edge, returns at the falling edge after the byte is taken
  task automatic send_byte(logic [7:0] c, logic eoi);
    while (!calm && $urandom_range(99) < 30) begin
      push <= 0;
      @(negedge clk_i);
    end
    push <= 1; char_byte_i <= c; end_of_input_i <= eoi;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s, logic close);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close && i == s.len() - 1);
  endtask

  initial begin
    byte unsigned c;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;
    send_text("var true false and or x_1 abcdefg 1.5 1. 2..3 == ++ -- = + - * / ", 0);
    send_text("()[]{},@\"ab\ncd\" #note\n\"open", 1);
    send_text("\x80\xff\x00\x7f3", 1);
    send_text("ab", 1);
    send_text("=", 1);
    for (int n = 0; n < 1200; n++) begin
      calm = (n >= 400 && n < 600);
      if (n == 700) hold_off = 1;
      if ($urandom_range(9) < 8) c = alphabet[$urandom_range(alphabet.size() - 1)];
      else c = 8'($urandom);
      send_byte(c, $urandom_range(40) == 0);
    end
    send_byte(" ", 1);
    push <= 0;
    fork
      begin
        wait (tokens_waiting == 0);
        repeat (20) @(posedge clk_i);
      end
      begin
        repeat (200000) @(posedge clk_i);
        $display("token_lexer verification failed");
        $finish;
      end
    join_any
    if (fail_count == 0 && tokens_waiting == 0) $display("token_lexer verification clean");
    else $display("token_lexer verification failed");
    $finish;
  end

  // result side, with one long hold-off to fill the queue
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        pop <= 0;
        repeat (200) @(negedge clk_i);
        hold_off = 0;
      end
      pop <= calm || ($urandom_range(99) >= 30);
    end
  end

  initial begin
    #5ms;
    $display("token_lexer verification failed");
    $finish;
  end
endmodule

// ===== token_lexer.f =====
+incdir+rtl/core
rtl/core/tlex_pkg.sv
rtl/core/tlex_front.sv
rtl/core/tlex_queue.sv
rtl/core/tlex_back.sv
rtl/core/token_lexer.sv
sim/token_lexer_checker.sv
sim/token_lexer_test.sv
